// ===== rtl/mcpwc_pkg.sv =====
package mcpwc_pkg;

  // channel count and timer width are fixed by the port fields
  localparam int NUM_CH = 4;
  localparam int CH_W   = $clog2(NUM_CH);
  localparam int TS_W   = 16;

  // packed stream word widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((NUM_CH + TS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CH_W + TS_W + 7) / 8) * 8;

  localparam logic [NUM_CH-1:0] EN_RESET = '1;

  // overflow count codes, count saturates at two
  localparam logic [1:0] OVF_NONE = 2'd0;
  localparam logic [1:0] OVF_ONE  = 2'd1;
  localparam logic [1:0] OVF_SAT  = 2'd2;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  // all pulses that ended on one sample
  typedef struct packed {
    logic [NUM_CH-1:0]           fall;
    logic [NUM_CH-1:0]           err;
    logic [NUM_CH-1:0][TS_W-1:0] width;
  } pulse_set_t;

  typedef struct packed {
    logic       valid;
    pulse_set_t set;
  } pulse_slot_t;

endpackage

// ===== rtl/mcpwc_front.sv =====
module mcpwc_front
  import mcpwc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  input  logic [NUM_CH-1:0] in_pins,
  input  logic [TS_W-1:0]   in_ts,
  output logic              in_ready,
  input  logic              cfg_valid,
  input  logic [NUM_CH-1:0] cfg_data,
  input  logic              full,
  output pulse_slot_t       push
);

  logic [NUM_CH-1:0]           en_r, en_nxt;
  logic [NUM_CH-1:0]           prev_r, prev_nxt;
  logic [NUM_CH-1:0][1:0]      ovf_r, ovf_nxt;
  logic [NUM_CH-1:0][TS_W-1:0] rise_r, rise_nxt;
  logic                        accept;
  op_t                         opcode;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign opcode   = op_t'(in_opcode);

  always_comb begin
    en_nxt   = en_r;
    prev_nxt = prev_r;
    ovf_nxt  = ovf_r;
    rise_nxt = rise_r;
    push     = '0;
    if (cfg_valid) begin
      en_nxt = cfg_data;
    end
    if (accept) begin
      unique case (opcode)
        OP_TICK: begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (ovf_r[c] != OVF_SAT) begin
              ovf_nxt[c] = ovf_r[c] + 2'd1;
            end
          end
        end
        OP_SAMPLE: begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (en_r[c]) begin
              prev_nxt[c] = in_pins[c];
              if (in_pins[c] && !prev_r[c]) begin
                ovf_nxt[c]  = OVF_NONE;
                rise_nxt[c] = in_ts;
              end else if (!in_pins[c] && prev_r[c]) begin
                push.set.fall[c] = 1'b1;
                if (ovf_r[c] >= OVF_SAT) begin
                  push.set.err[c] = 1'b1;
                end else if (ovf_r[c] == OVF_ONE && in_ts >= rise_r[c]) begin
                  // wrapped once and ran past the start: saturate
                  push.set.width[c] = '1;
                end else begin
                  push.set.width[c] = in_ts - rise_r[c];
                end
              end
            end
          end
          push.valid = |push.set.fall;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= EN_RESET;
      prev_r <= '0;
      ovf_r  <= '0;
    end else begin
      en_r   <= en_nxt;
      prev_r <= prev_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // start times need no reset, read only after a rising edge wrote them
  always_ff @(posedge clk) begin
    rise_r <= rise_nxt;
  end

  a_tick_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && opcode == OP_TICK) |-> !push.valid)
    else $error("overflow tick produced pulse results");

endmodule

// ===== rtl/mcpwc_queue.sv =====
module mcpwc_queue
  import mcpwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pulse_slot_t push,
  input  logic        pop,
  output logic        full,
  output pulse_slot_t head
);

  // two slots, slot 0 is the head
  logic       v0_r, v0_nxt, v1_r, v1_nxt;
  pulse_set_t e0_r, e0_nxt, e1_r, e1_nxt;
  logic       v0_p, v1_p;
  pulse_set_t e0_p;

  assign full       = v1_r;
  assign head.valid = v0_r;
  assign head.set   = e0_r;

  always_comb begin
    v0_p   = pop ? v1_r : v0_r;
    v1_p   = pop ? 1'b0 : v1_r;
    e0_p   = pop ? e1_r : e0_r;
    v0_nxt = v0_p;
    v1_nxt = v1_p;
    e0_nxt = e0_p;
    e1_nxt = e1_r;
    if (push.valid) begin
      if (!v0_p) begin
        v0_nxt = 1'b1;
        e0_nxt = push.set;
      end else begin
        v1_nxt = 1'b1;
        e1_nxt = push.set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  a_fill_order: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> v0_r)
    else $error("second slot valid with empty head");

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> !v1_r)
    else $error("push into full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> v0_r)
    else $error("pop from empty queue");

endmodule

// ===== rtl/mcpwc_back.sv =====
module mcpwc_back
  import mcpwc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  pulse_slot_t     head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CH_W-1:0] out_channel,
  output logic [TS_W-1:0] out_width,
  output logic            out_err,
  output logic            out_last
);

  logic [NUM_CH-1:0] done_r, done_nxt;
  logic              valid_r, valid_nxt;
  logic [CH_W-1:0]   ch_r;
  logic [TS_W-1:0]   width_r;
  logic              err_r, last_r;
  logic [NUM_CH-1:0] pending, sel_oh, rest;
  logic [CH_W-1:0]   sel;
  logic              load, last;

  always_comb begin
    pending = head.valid ? (head.set.fall & ~done_r) : '0;
    sel     = '0;
    sel_oh  = '0;
    // lowest pending channel goes first
    for (int c = NUM_CH - 1; c >= 0; c--) begin
      if (pending[c]) begin
        sel    = CH_W'(c);
        sel_oh = '0;
        sel_oh[c] = 1'b1;
      end
    end
    rest = pending & ~sel_oh;
    last = (rest == '0);
    load = (|pending) && (!valid_r || out_ready);
    pop  = load && last;
    if (pop) begin
      done_nxt = '0;
    end else if (load) begin
      done_nxt = done_r | sel_oh;
    end else begin
      done_nxt = done_r;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r    <= sel;
      width_r <= head.set.width[sel];
      err_r   <= head.set.err[sel];
      last_r  <= last;
    end
  end

  assign out_valid   = valid_r;
  assign out_channel = ch_r;
  assign out_width   = width_r;
  assign out_err     = err_r;
  assign out_last    = last_r;

  a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r & ~head.set.fall) == '0 || !head.valid)
    else $error("finished mask has channels outside head entry");

  a_done_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head.valid |-> done_r == '0)
    else $error("finished mask left over with no head entry");

endmodule

// ===== rtl/multi_channel_pulse_width_capture_top.sv =====
// four-channel rc receiver pulse-width capture
//
// in_* stream: one word per pin sample or timer overflow tick. in_tuser is the
//   opcode (0 = pin sample, 1 = overflow tick); in_tdata carries the pin levels
//   and the free-running timestamp of the sample.
// out_* stream: one word per falling edge on an enabled channel, ascending
//   channel order within a sample, out_tlast on the final word of a sample.
//   out_tuser flags an overflow error (two or more timer wraps, width zero).
// cfg_*: write of the channel enable mask, always ready, take effect on the
//   next sample; write only while no sample is still draining.
// timing: a sample is classified in the cycle it is accepted; its first result
//   passes through a queue slot and the output register before out_tvalid.
// throughput: one word per cycle on each side while the queue has room and the
//   receiver is ready; a sample gives one output word per falling edge, and
//   ticks and edgeless samples give none; a two-entry queue between classifier and
//   serializer absorbs bursts; in_tready drops only while both entries wait.
// reset: levels low, overflow counts zero, all channels enabled, queue and
//   output register empty. when the receiver stalls, the output word holds
//   and the queue fills, then the input side stalls.
module multi_channel_pulse_width_capture_top
  import mcpwc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // pin_levels, timestamp, zero fill
  input  logic                   in_tuser,   // opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // channel, pulse_width, zero fill
  output logic                   out_tuser,  // overflow_error
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [NUM_CH-1:0]      cfg_data    // channel_enable
);

  pulse_slot_t     push, head;
  logic            full, pop;
  logic [CH_W-1:0] out_channel;
  logic [TS_W-1:0] out_width;

  // config register is a plain flop write, never busy
  assign cfg_ready = 1'b1;

  // front: edge detect, per-channel state and width arithmetic
  mcpwc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_pins   (in_tdata[NUM_CH-1:0]),
    .in_ts     (in_tdata[NUM_CH +: TS_W]),
    .in_ready  (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .full      (full),
    .push      (push)
  );

  // queue of finished pulse sets
  mcpwc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (full),
    .head  (head)
  );

  // back: one result word per cycle from the head pulse set while out_tready is high
  mcpwc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_channel (out_channel),
    .out_width   (out_width),
    .out_err     (out_tuser),
    .out_last    (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W - CH_W - TS_W){1'b0}}, out_width, out_channel};

endmodule
